### design/obla_pkg.sv
// ----------------------------------------------------------------------------
// obla_pkg: shared types and constants of the order book level aggregator
// Table depths, message and reject codes, and the records that move
// between the front queue and the back engine.
// ----------------------------------------------------------------------------
package obla_pkg;

    localparam int ORDER_SLOTS = 1024;
    localparam int ORDER_AW    = $clog2(ORDER_SLOTS);
    localparam int LEVEL_SLOTS = 64;
    localparam int LEVEL_AW    = $clog2(LEVEL_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_MODIFY  = 2'd1;
    localparam logic [1:0] OP_EXECUTE = 2'd2;
    localparam logic [1:0] OP_DELETE  = 2'd3;

    localparam logic [2:0] REJ_OK      = 3'd0;
    localparam logic [2:0] REJ_DUP_ID  = 3'd1;
    localparam logic [2:0] REJ_UNKNOWN = 3'd2;
    localparam logic [2:0] REJ_CROSS   = 3'd3;
    localparam logic [2:0] REJ_BAD_QTY = 3'd4;
    localparam logic [2:0] REJ_FULL    = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] order_ref;
        logic        sell;
        logic [63:0] price;
        logic [31:0] quantity;
        logic        qty_zero;
    } t_req;

    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic        sell;
        logic [63:0] price;
        logic [31:0] remaining;
    } t_order;

    typedef struct packed {
        logic [63:0] price;
        logic [31:0] size;
    } t_level;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  reject_reason;
        logic        bid_present;
        logic [63:0] best_bid_price;
        logic [31:0] best_bid_size;
        logic        ask_present;
        logic [63:0] best_ask_price;
        logic [31:0] best_ask_size;
    } t_result;

    typedef struct packed {
        logic hold;
        logic pop;
    } t_queue_ctl;

endpackage

### design/obla_front.sv
// ----------------------------------------------------------------------------
// obla_front: request intake queue
// Accept requests, classify them and hold them in a short queue until the
// back engine takes them.
// ----------------------------------------------------------------------------
module obla_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_op,
    input  logic [63:0]          i_order_ref,
    input  logic                 i_side,
    input  logic signed [63:0]   i_price,
    input  logic [31:0]          i_quantity,
    input  obla_pkg::t_queue_ctl i_ctl,
    output logic                 o_req_valid,
    output obla_pkg::t_req       o_req
);

    obla_pkg::t_req                   r_mem [obla_pkg::QUEUE_DEPTH];
    logic [obla_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [obla_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [obla_pkg::QUEUE_AW:0]      r_count;
    logic                             w_push;
    logic                             w_pop;
    obla_pkg::t_req                   w_new;

    assign o_in_stall  = (r_count == (obla_pkg::QUEUE_AW+1)'(obla_pkg::QUEUE_DEPTH)) || i_ctl.hold;
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_count != '0);
    assign w_pop       = i_ctl.pop && o_req_valid;
    assign o_req       = r_mem[r_rd_ptr];

    always_comb begin
        w_new.op        = i_op;
        w_new.order_ref = i_order_ref;
        w_new.sell      = i_side;
        w_new.price     = i_price;
        w_new.quantity  = i_quantity;
        w_new.qty_zero  = (i_quantity == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/obla_engine.sv
// ----------------------------------------------------------------------------
// obla_engine: order and price level sequencer
// Scan the order table and both level tables, check, and if accepted apply
// the writes and rescan for the top of book; register the response.
// ----------------------------------------------------------------------------
module obla_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  obla_pkg::t_req       i_req,
    output obla_pkg::t_queue_ctl o_ctl,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output obla_pkg::t_result    o_out
);

    localparam int OAW = obla_pkg::ORDER_AW;
    localparam int LAW = obla_pkg::LEVEL_AW;
    localparam int LS  = obla_pkg::LEVEL_SLOTS;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_OSCAN  = 4'd2;
    localparam logic [3:0] S_LINIT  = 4'd3;
    localparam logic [3:0] S_LSCAN  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_W1     = 4'd6;
    localparam logic [3:0] S_W2     = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // memories
    obla_pkg::t_order r_omem [obla_pkg::ORDER_SLOTS];
    obla_pkg::t_level r_bmem [LS];
    obla_pkg::t_level r_amem [LS];
    obla_pkg::t_order r_ord;
    obla_pkg::t_level r_bid_rd;
    obla_pkg::t_level r_ask_rd;

    logic [3:0]         r_state;
    logic [OAW:0]       r_addr;
    logic [LAW:0]       r_laddr;
    logic               r_chk;
    logic [OAW-1:0]     r_chk_oaddr;
    logic [LAW-1:0]     r_chk_laddr;
    logic               r_final;
    obla_pkg::t_req     r_req;

    logic               r_of;
    logic [OAW-1:0]     r_oidx;
    logic               r_osell;
    logic [63:0]        r_oprice;
    logic [31:0]        r_orem;
    logic               r_ofv;
    logic [OAW-1:0]     r_ofidx;

    logic [LS-1:0]      r_bid_used;
    logic [LS-1:0]      r_ask_used;
    logic               r_bb_v;
    logic [63:0]        r_bb_px;
    logic [31:0]        r_bb_sz;
    logic               r_ab_v;
    logic [63:0]        r_ab_px;
    logic [31:0]        r_ab_sz;
    logic               r_nf;
    logic [LAW-1:0]     r_nidx;
    logic [31:0]        r_nsize;
    logic               r_lf;
    logic [LAW-1:0]     r_lidx;
    logic [31:0]        r_lsize;
    logic [2:0]         r_reason;
    logic               r_out_valid;
    obla_pkg::t_result  r_out;

    logic               w_sell;
    logic [LS-1:0]      w_side_used;
    logic               w_lfree_v;
    logic [LAW-1:0]     w_lfree;
    logic               w_cross;
    logic               w_frees;
    logic [2:0]         w_reason;
    logic [31:0]        w_sub_amt;
    logic [31:0]        w_sub_size;
    logic [31:0]        w_add_size;
    logic [31:0]        w_exec_rem;
    logic               w_om_we;
    logic [OAW-1:0]     w_om_waddr;
    obla_pkg::t_order   w_om_wdata;
    logic               w_lv_we;
    logic [LAW-1:0]     w_lv_waddr;
    obla_pkg::t_level   w_lv_wdata;
    obla_pkg::t_level   w_side_rd;
    logic               w_side_hit;

    assign o_ctl.hold  = (r_state == S_CLEAR);
    assign o_ctl.pop   = (r_state == S_IDLE) && i_req_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_sell      = (r_req.op == obla_pkg::OP_ADD) ? r_req.sell : r_osell;
    assign w_side_used = w_sell ? r_ask_used : r_bid_used;
    assign w_side_rd   = w_sell ? r_ask_rd : r_bid_rd;
    assign w_side_hit  = w_side_used[r_chk_laddr];
    assign w_exec_rem  = r_orem - r_req.quantity;
    assign w_sub_amt   = (r_req.op == obla_pkg::OP_EXECUTE) ? r_req.quantity : r_orem;
    assign w_sub_size  = r_lsize - w_sub_amt;
    assign w_add_size  = r_nsize + r_req.quantity;
    assign w_frees     = r_lf && (r_lsize == r_orem);

    // lowest free level slot on the active side
    always_comb begin
        w_lfree_v = 1'b0;
        w_lfree   = '0;
        for (int i = LS - 1; i >= 0; i--) begin
            if (!w_side_used[i]) begin
                w_lfree_v = 1'b1;
                w_lfree   = LAW'(i);
            end
        end
    end

    always_comb begin
        if (w_sell) begin
            w_cross = r_bb_v && ($signed(r_req.price) <= $signed(r_bb_px));
        end else begin
            w_cross = r_ab_v && ($signed(r_req.price) >= $signed(r_ab_px));
        end
    end

    always_comb begin
        w_reason = obla_pkg::REJ_OK;
        unique case (r_req.op)
            obla_pkg::OP_ADD: begin
                if (r_of) begin
                    w_reason = obla_pkg::REJ_DUP_ID;
                end else if (r_req.qty_zero) begin
                    w_reason = obla_pkg::REJ_BAD_QTY;
                end else if (w_cross) begin
                    w_reason = obla_pkg::REJ_CROSS;
                end else if (!r_ofv || (!r_nf && !w_lfree_v)) begin
                    w_reason = obla_pkg::REJ_FULL;
                end
            end
            obla_pkg::OP_MODIFY: begin
                if (!r_of) begin
                    w_reason = obla_pkg::REJ_UNKNOWN;
                end else if (r_req.qty_zero) begin
                    w_reason = obla_pkg::REJ_BAD_QTY;
                end else if (w_cross) begin
                    w_reason = obla_pkg::REJ_CROSS;
                end else if (!r_nf && !w_lfree_v && !w_frees) begin
                    w_reason = obla_pkg::REJ_FULL;
                end
            end
            obla_pkg::OP_EXECUTE: begin
                if (!r_of) begin
                    w_reason = obla_pkg::REJ_UNKNOWN;
                end else if (r_req.quantity > r_orem) begin
                    w_reason = obla_pkg::REJ_BAD_QTY;
                end
            end
            default: begin
                if (!r_of) begin
                    w_reason = obla_pkg::REJ_UNKNOWN;
                end
            end
        endcase
    end

    // table write ports
    always_comb begin
        w_om_we    = 1'b0;
        w_om_waddr = r_addr[OAW-1:0];
        w_om_wdata = '0;
        w_lv_we    = 1'b0;
        w_lv_waddr = r_lidx;
        w_lv_wdata.price = r_oprice;
        w_lv_wdata.size  = w_sub_size;
        if (r_state == S_CLEAR) begin
            w_om_we = 1'b1;
        end else if (r_state == S_W1) begin
            w_om_we              = 1'b1;
            w_om_wdata.used      = 1'b1;
            w_om_wdata.key       = r_req.order_ref;
            w_om_wdata.sell      = w_sell;
            w_om_wdata.price     = r_req.price;
            w_om_wdata.remaining = r_req.quantity;
            w_om_waddr           = r_oidx;
            case (r_req.op)
                obla_pkg::OP_ADD: begin
                    w_om_waddr = r_ofidx;
                end
                obla_pkg::OP_EXECUTE: begin
                    w_om_wdata.used      = (w_exec_rem != '0);
                    w_om_wdata.price     = r_oprice;
                    w_om_wdata.remaining = w_exec_rem;
                end
                obla_pkg::OP_DELETE: begin
                    w_om_wdata.used = 1'b0;
                end
                default: begin
                end
            endcase
            w_lv_we = (r_req.op != obla_pkg::OP_ADD) && r_lf;
        end else if (r_state == S_W2) begin
            w_lv_we          = 1'b1;
            w_lv_wdata.price = r_req.price;
            if (r_nf) begin
                w_lv_waddr      = r_nidx;
                w_lv_wdata.size = w_add_size;
            end else begin
                w_lv_waddr      = w_lfree;
                w_lv_wdata.size = r_req.quantity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_om_we) begin
            r_omem[w_om_waddr] <= w_om_wdata;
        end
        r_ord <= r_omem[r_addr[OAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_lv_we && !w_sell) begin
            r_bmem[w_lv_waddr] <= w_lv_wdata;
        end
        if (w_lv_we && w_sell) begin
            r_amem[w_lv_waddr] <= w_lv_wdata;
        end
        r_bid_rd <= r_bmem[r_laddr[LAW-1:0]];
        r_ask_rd <= r_amem[r_laddr[LAW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_laddr     <= '0;
            r_chk       <= 1'b0;
            r_final     <= 1'b0;
            r_bid_used  <= '0;
            r_ask_used  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new response, or drop the one just taken
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == (OAW+1)'(obla_pkg::ORDER_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_of    <= 1'b0;
                        r_ofv   <= 1'b0;
                        r_addr  <= '0;
                        r_chk   <= 1'b0;
                        r_state <= S_OSCAN;
                    end
                end
                S_OSCAN: begin
                    r_chk       <= !r_addr[OAW];
                    r_chk_oaddr <= r_addr[OAW-1:0];
                    if (!r_addr[OAW]) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_chk) begin
                        if (r_ord.used && (r_ord.key == r_req.order_ref)) begin
                            r_of     <= 1'b1;
                            r_oidx   <= r_chk_oaddr;
                            r_osell  <= r_ord.sell;
                            r_oprice <= r_ord.price;
                            r_orem   <= r_ord.remaining;
                            r_final  <= 1'b0;
                            r_state  <= S_LINIT;
                        end else begin
                            if (!r_ord.used && !r_ofv) begin
                                r_ofv   <= 1'b1;
                                r_ofidx <= r_chk_oaddr;
                            end
                            if (r_chk_oaddr == OAW'(obla_pkg::ORDER_SLOTS - 1)) begin
                                r_final <= 1'b0;
                                r_state <= S_LINIT;
                            end
                        end
                    end
                end
                S_LINIT: begin
                    r_laddr <= '0;
                    r_chk   <= 1'b0;
                    r_bb_v  <= 1'b0;
                    r_ab_v  <= 1'b0;
                    if (!r_final) begin
                        r_nf <= 1'b0;
                        r_lf <= 1'b0;
                    end
                    r_state <= S_LSCAN;
                end
                S_LSCAN: begin
                    r_chk       <= !r_laddr[LAW];
                    r_chk_laddr <= r_laddr[LAW-1:0];
                    if (!r_laddr[LAW]) begin
                        r_laddr <= r_laddr + 1'b1;
                    end
                    if (r_chk) begin
                        if (r_bid_used[r_chk_laddr] && (!r_bb_v ||
                            ($signed(r_bid_rd.price) > $signed(r_bb_px)))) begin
                            r_bb_v  <= 1'b1;
                            r_bb_px <= r_bid_rd.price;
                            r_bb_sz <= r_bid_rd.size;
                        end
                        if (r_ask_used[r_chk_laddr] && (!r_ab_v ||
                            ($signed(r_ask_rd.price) < $signed(r_ab_px)))) begin
                            r_ab_v  <= 1'b1;
                            r_ab_px <= r_ask_rd.price;
                            r_ab_sz <= r_ask_rd.size;
                        end
                        if (!r_final && w_side_hit && (w_side_rd.price == r_req.price)) begin
                            r_nf    <= 1'b1;
                            r_nidx  <= r_chk_laddr;
                            r_nsize <= w_side_rd.size;
                        end
                        if (!r_final && w_side_hit && (w_side_rd.price == r_oprice)) begin
                            r_lf    <= 1'b1;
                            r_lidx  <= r_chk_laddr;
                            r_lsize <= w_side_rd.size;
                        end
                        if (r_chk_laddr == LAW'(LS - 1)) begin
                            r_state <= r_final ? S_OUT : S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_reason <= w_reason;
                    r_state  <= (w_reason == obla_pkg::REJ_OK) ? S_W1 : S_OUT;
                end
                S_W1: begin
                    // take the old amount out of the old level
                    if (w_lv_we && (w_sub_size == '0)) begin
                        if (w_sell) begin
                            r_ask_used[r_lidx] <= 1'b0;
                        end else begin
                            r_bid_used[r_lidx] <= 1'b0;
                        end
                    end
                    if (w_lv_we && r_nf && (r_nidx == r_lidx)) begin
                        r_nsize <= w_sub_size;
                        if (w_sub_size == '0) begin
                            r_nf <= 1'b0;
                        end
                    end
                    r_final <= 1'b1;
                    if ((r_req.op == obla_pkg::OP_ADD) || (r_req.op == obla_pkg::OP_MODIFY)) begin
                        r_state <= S_W2;
                    end else begin
                        r_state <= S_LINIT;
                    end
                end
                S_W2: begin
                    if (w_sell) begin
                        r_ask_used[w_lv_waddr] <= !r_nf || (w_add_size != '0);
                    end else begin
                        r_bid_used[w_lv_waddr] <= !r_nf || (w_add_size != '0);
                    end
                    r_state <= S_LINIT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.accepted       <= (r_reason == obla_pkg::REJ_OK);
                        r_out.reject_reason  <= r_reason;
                        r_out.bid_present    <= r_bb_v;
                        r_out.best_bid_price <= r_bb_v ? r_bb_px : '0;
                        r_out.best_bid_size  <= r_bb_v ? r_bb_sz : '0;
                        r_out.ask_present    <= r_ab_v;
                        r_out.best_ask_price <= r_ab_v ? r_ab_px : '0;
                        r_out.best_ask_size  <= r_ab_v ? r_ab_sz : '0;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_w2_after_w1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W2) |-> ($past(r_state) == S_W1))
        else $error("level add step without preceding subtract step");

    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.accepted == (r_out.reject_reason == obla_pkg::REJ_OK)))
        else $error("accept flag disagrees with reject code");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ctl.pop)
        else $error("request taken during table clear");

    a_empty_bid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.bid_present) |->
        ((r_out.best_bid_price == '0) && (r_out.best_bid_size == '0)))
        else $error("empty bid side reports a level");

    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (r_reason != obla_pkg::REJ_OK)) |-> !r_final)
        else $error("rejected request went through the write steps");
`endif

endmodule

### design/order_book_level_aggregator.sv
// ----------------------------------------------------------------------------
// order_book_level_aggregator: top of book from add/modify/execute/delete
// Keeps resting orders and per-side price levels; reports status and the
// best bid and ask after every request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid with one request (op, order key, side, price,
//   quantity); the block raises o_in_stall when it cannot take it. A
//   request is taken on a rising edge with i_in_valid high and o_in_stall
//   low. Output channel: o_out_valid with one response, held until a
//   rising edge with i_out_stall low.
//   Sequence: the back engine scans the order table one entry a cycle
//   until the order key matches (all ORDER_SLOTS entries when no key
//   matches), then scans the level tables and checks the request; an
//   accepted one applies up to two write steps and rescans the levels.
//   The response is then registered.
//   A two-entry queue in front lets requests be taken while the engine
//   works and while a response waits on a stalled receiver.
//   Reset: level valid bits clear at once; the order table is then
//   cleared one entry a cycle over all ORDER_SLOTS entries, and
//   o_in_stall stays high until it is done.
// ----------------------------------------------------------------------------
module order_book_level_aggregator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [63:0]         i_order_ref,
    input  logic                i_side,
    input  logic signed [63:0]  i_price,
    input  logic [31:0]         i_quantity,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_accepted,
    output logic [2:0]          o_reject_reason,
    output logic                o_bid_present,
    output logic signed [63:0]  o_best_bid_price,
    output logic [31:0]         o_best_bid_size,
    output logic                o_ask_present,
    output logic signed [63:0]  o_best_ask_price,
    output logic [31:0]         o_best_ask_size
);

    // queue handshake between intake and engine
    obla_pkg::t_queue_ctl w_ctl;
    logic                 w_req_valid;
    obla_pkg::t_req       w_req;
    obla_pkg::t_result    w_out;

    // intake: take and classify requests
    obla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_order_ref (i_order_ref),
        .i_side      (i_side),
        .i_price     (i_price),
        .i_quantity  (i_quantity),
        .i_ctl       (w_ctl),
        .o_req_valid (w_req_valid),
        .o_req       (w_req)
    );

    // engine: lookups, checks, table updates, top of book
    obla_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_ctl       (w_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (w_out)
    );

    // unpack the registered response
    assign o_accepted       = w_out.accepted;
    assign o_reject_reason  = w_out.reject_reason;
    assign o_bid_present    = w_out.bid_present;
    assign o_best_bid_price = w_out.best_bid_price;
    assign o_best_bid_size  = w_out.best_bid_size;
    assign o_ask_present    = w_out.ask_present;
    assign o_best_ask_price = w_out.best_ask_price;
    assign o_best_ask_size  = w_out.best_ask_size;

endmodule
